@@ hw/rtl/xcf_pkg.sv @@
package xcf_pkg;

  // Default longest line, in bytes including the newline position
  localparam int LINE_MAX_DEF = 128;

  // Framing characters
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Checksum status codes
  localparam logic [1:0] ST_NONE     = 2'd0;
  localparam logic [1:0] ST_MATCH    = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;

  localparam int OUT_BITS = 25;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [7:0] received_sum;
    logic [7:0] computed_sum;
    logic [6:0] body_length;
    logic [1:0] check_status;
  } xcf_res_t;

  // Bit 4 set: not a hex digit; bits 3:0 digit value otherwise
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b inside {[8'h30:8'h39]}) begin
      v = {1'b0, 4'(b - 8'h30)};
    end else if (b inside {[8'h41:8'h46]}) begin
      v = {1'b0, 4'(b - 8'h41 + 8'd10)};
    end else if (b inside {[8'h61:8'h66]}) begin
      v = {1'b0, 4'(b - 8'h61 + 8'd10)};
    end
    return v;
  endfunction

endpackage

@@ hw/rtl/xcf_in_stage.sv @@
module xcf_in_stage import xcf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       go,
  output logic       stage_valid,
  output logic [7:0] stage_byte
);

  logic       valid_r;
  logic [7:0] byte_r;

  assign in_ready    = !valid_r || go;
  assign stage_valid = valid_r;
  assign stage_byte  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (go) begin
      valid_r <= 1'b0;
    end
  end

  // Payload: load on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

endmodule

@@ hw/rtl/xcf_line_core.sv @@
module xcf_line_core import xcf_pkg::*; #(
  parameter int LINE_MAX = LINE_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output xcf_res_t   res
);

  localparam int LCW = $clog2(LINE_MAX);

  logic [LCW-1:0] line_count_r, line_count_nxt;
  logic [LCW-1:0] body_count_r, body_count_nxt;
  logic           discarding_r, discarding_nxt;
  logic           in_ck_r, in_ck_nxt;
  logic           hex_ended_r, hex_ended_nxt;
  logic           zero_seen_r, zero_seen_nxt;
  logic [7:0]     xor_r, xor_nxt;
  logic [7:0]     hex_r, hex_nxt;
  logic [4:0]     digit;

  assign digit = hex_value(rx_byte);

  always_comb begin
    line_count_nxt = line_count_r;
    body_count_nxt = body_count_r;
    discarding_nxt = discarding_r;
    in_ck_nxt      = in_ck_r;
    hex_ended_nxt  = hex_ended_r;
    zero_seen_nxt  = zero_seen_r;
    xor_nxt        = xor_r;
    hex_nxt        = hex_r;
    res_valid      = 1'b0;
    res.check_status = in_ck_r ? ((hex_r == xor_r) ? ST_MATCH : ST_MISMATCH) : ST_NONE;
    res.received_sum = in_ck_r ? hex_r : 8'h00;
    res.computed_sum = xor_r;
    res.body_length  = 7'(body_count_r);

    if (fire && rx_byte != CH_CR) begin
      if (discarding_r) begin
        if (rx_byte == CH_LF) begin
          discarding_nxt = 1'b0;
        end
      end else if (rx_byte == CH_LF || line_count_r >= LCW'(LINE_MAX - 1)) begin
        // End of line or overlong line: emit or drop, then clear the line
        if (rx_byte == CH_LF) begin
          res_valid = (line_count_r != '0);
        end else begin
          discarding_nxt = 1'b1;
        end
        line_count_nxt = '0;
        body_count_nxt = '0;
        in_ck_nxt      = 1'b0;
        hex_ended_nxt  = 1'b0;
        zero_seen_nxt  = 1'b0;
        xor_nxt        = 8'h00;
        hex_nxt        = 8'h00;
      end else begin
        line_count_nxt = line_count_r + LCW'(1);
        if (line_count_r == '0 && rx_byte == CH_DOLLAR) begin
          // skip leading dollar
        end else if (zero_seen_r) begin
          // body closed by a zero byte
        end else if (in_ck_r) begin
          if (!hex_ended_r) begin
            if (digit[4]) begin
              hex_ended_nxt = 1'b1;
            end else begin
              hex_nxt = {hex_r[3:0], digit[3:0]};
            end
          end
        end else if (rx_byte == CH_NUL) begin
          zero_seen_nxt = 1'b1;
        end else if (rx_byte == CH_STAR) begin
          in_ck_nxt = 1'b1;
        end else begin
          xor_nxt        = xor_r ^ rx_byte;
          body_count_nxt = body_count_r + LCW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r <= '0;
      body_count_r <= '0;
      discarding_r <= 1'b0;
      in_ck_r      <= 1'b0;
      hex_ended_r  <= 1'b0;
      zero_seen_r  <= 1'b0;
      xor_r        <= 8'h00;
      hex_r        <= 8'h00;
    end else begin
      line_count_r <= line_count_nxt;
      body_count_r <= body_count_nxt;
      discarding_r <= discarding_nxt;
      in_ck_r      <= in_ck_nxt;
      hex_ended_r  <= hex_ended_nxt;
      zero_seen_r  <= zero_seen_nxt;
      xor_r        <= xor_nxt;
      hex_r        <= hex_nxt;
    end
  end

endmodule

@@ hw/rtl/xcf_out_reg.sv @@
module xcf_out_reg import xcf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  xcf_res_t   res,
  output logic       go,
  output logic       out_valid,
  input  logic       out_ready,
  output xcf_res_t   out_res
);

  logic     valid_r;
  xcf_res_t res_r;

  // The stage ahead may advance when the slot is empty or drains this cycle
  assign go        = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

@@ hw/rtl/xor_checksum_line_framer.sv @@
// Line framer with an XOR checksum check in the style of NMEA sentences. Feed
// received bytes, one item per cycle; lines end at newline and carriage returns
// are ignored. Each non-empty line gives one result item: checksum status
// (0 none, 1 match, 2 mismatch), body length, XOR of the body and the received
// checksum (last two hex digits after '*'). One leading '$' is skipped; a zero
// byte or '*' ends the body. A line of LINE_MAX-1 stored bytes is still checked;
// a byte that would make it longer drops the line, and everything up to the
// next newline is discarded silently. The block takes one byte every cycle: an
// input register feeds the line-state update, and a result register holds the
// outgoing item, so a result item passes through the input register and then the
// result register after its newline is accepted. Input stalls only while both
// registers are full and out_tready is low.
module xor_checksum_line_framer import xcf_pkg::*; #(
  parameter int LINE_MAX = LINE_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] rx_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [1:0] check_status, [8:2] body_length, [16:9] computed_sum,
  // [24:17] received_sum, upper bits zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic       go;
  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       fire;
  logic       res_valid;
  xcf_res_t   res;
  xcf_res_t   out_res;

  // Input register: hold one byte until the core can take it
  xcf_in_stage u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_byte     (in_tdata),
    .go          (go),
    .stage_valid (stage_valid),
    .stage_byte  (stage_byte)
  );

  // Advance the line state whenever a byte is waiting and the result slot is free or draining
  assign fire = stage_valid && go;

  xcf_line_core #(
    .LINE_MAX (LINE_MAX)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .rx_byte   (stage_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register: load on a newline that closes a non-empty line
  xcf_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .go        (go),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = OUT_DATA_W'(out_res);

endmodule

@@ bench/xcf_line_checker.sv @@
module xcf_line_checker import xcf_pkg::*; #(
  parameter int LINE_MAX = LINE_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    fail_count,
  output int                    lines_pending,
  output int                    lines_checked,
  output int                    overlong_drops,
  output int                    n_match,
  output int                    n_mismatch,
  output int                    n_plain
);

  // Line state of the predictor
  logic [6:0] stored_len;
  logic       flushing;
  logic       after_star;
  logic       digits_done;
  logic       nul_hit;
  logic [7:0] run_xor;
  logic [7:0] rx_sum;
  logic [6:0] body_len;

  xcf_res_t line_results[$];

  task automatic flag_error(input string what, input int got, input int want);
    $display("checker: %s: got %0d, want %0d (line result %0d)", what, got, want,
             lines_checked);
    fail_count++;
  endtask

  task automatic clear_line_state();
    stored_len  = '0;
    after_star  = 1'b0;
    digits_done = 1'b0;
    nul_hit     = 1'b0;
    run_xor     = '0;
    rx_sum      = '0;
    body_len    = '0;
  endtask

  // Bit 4 flags a byte that is no hex digit
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      return {1'b0, c[3:0] + 4'd9};
    return 5'h10;
  endfunction

  // Advance the line state by one byte; queue a result at a non-empty newline
  task automatic frame_byte(input logic [7:0] c);
    logic [4:0] d;
    xcf_res_t   r;
    if (c == CH_CR) return;
    if (flushing) begin
      if (c == CH_LF) flushing = 1'b0;
      return;
    end
    if (c == CH_LF) begin
      if (stored_len == 0) return;
      if (after_star) begin
        r.check_status = (rx_sum == run_xor) ? ST_MATCH : ST_MISMATCH;
        r.received_sum = rx_sum;
      end else begin
        r.check_status = ST_NONE;
        r.received_sum = 8'h00;
      end
      r.body_length  = body_len;
      r.computed_sum = run_xor;
      line_results.push_back(r);
      clear_line_state();
      return;
    end
    if (int'(stored_len) >= LINE_MAX - 1) begin
      clear_line_state();
      flushing = 1'b1;
      overlong_drops++;
      return;
    end
    stored_len++;
    if (stored_len == 7'd1 && c == CH_DOLLAR) return;
    if (nul_hit) return;
    if (after_star) begin
      if (!digits_done) begin
        d = digit_of(c);
        if (d[4]) digits_done = 1'b1;
        else rx_sum = {rx_sum[3:0], d[3:0]};
      end
      return;
    end
    if (c == CH_NUL) begin
      nul_hit = 1'b1;
      return;
    end
    if (c == CH_STAR) begin
      after_star = 1'b1;
      return;
    end
    run_xor ^= c;
    body_len++;
  endtask

  always @(posedge clk) begin
    xcf_res_t got;
    xcf_res_t want;
    if (!rst_n) begin
      clear_line_state();
      flushing = 1'b0;
      line_results.delete();
    end else begin
      // Predict first, so a same-edge result could still find its line
      if (in_tvalid && in_tready) frame_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        got = out_tdata[OUT_BITS-1:0];
        if ((out_tdata >> OUT_BITS) != 0)
          flag_error("padding bits not zero", int'(out_tdata >> OUT_BITS), 0);
        if (line_results.size() == 0) begin
          flag_error("result with no line pending", int'(got), -1);
        end else begin
          want = line_results.pop_front();
          if (got.check_status != want.check_status)
            flag_error("check_status", got.check_status, want.check_status);
          if (got.body_length != want.body_length)
            flag_error("body_length", got.body_length, want.body_length);
          if (got.computed_sum != want.computed_sum)
            flag_error("computed_sum", got.computed_sum, want.computed_sum);
          if (got.received_sum != want.received_sum)
            flag_error("received_sum", got.received_sum, want.received_sum);
          case (want.check_status)
            ST_MATCH:    n_match++;
            ST_MISMATCH: n_mismatch++;
            default:     n_plain++;
          endcase
        end
        lines_checked++;
      end
    end
    lines_pending = line_results.size();
  end

endmodule

@@ bench/tb_xor_checksum_line_framer.sv @@
module tb_xor_checksum_line_framer;
  import xcf_pkg::*;

  localparam int RANDOM_BYTES = 1900;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = 8'h00;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  int fail_count, lines_pending, lines_checked, overlong_drops;
  int n_match, n_mismatch, n_plain;
  int bytes_sent = 0;
  int cycles     = 0;
  bit tx_burst   = 1'b0;   // sender runs back to back while set
  bit rx_burst   = 1'b0;   // receiver never stalls while set

  // Two delays: high, then low; period of 2
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  xor_checksum_line_framer #(.LINE_MAX(LINE_MAX_DEF)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),     // [7:0] rx_byte
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)     // [1:0] status, [8:2] length, [16:9] xor, [24:17] rx sum
  );

  xcf_line_checker #(.LINE_MAX(LINE_MAX_DEF)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .lines_pending (lines_pending),
    .lines_checked (lines_checked),
    .overlong_drops(overlong_drops),
    .n_match       (n_match),
    .n_mismatch    (n_mismatch),
    .n_plain       (n_plain)
  );

  // Watchdog: end the run if the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d line results outstanding", cycles,
               lines_pending);
      $display("tb_xor_checksum_line_framer: errors");
      $finish;
    end
  end

  // Offer one byte after a random gap and hold it until accepted. Valid stays
  // high across back-to-back items so it is never dropped and raised in one step.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] xor_of(input string s);
    logic [7:0] x;
    x = 8'h00;
    for (int i = 0; i < s.len(); i++) x ^= s[i];
    return x;
  endfunction

  // Result side: stall a random number of cycles per item, with stretches
  // where ready stays high throughout
  initial begin
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    logic [7:0]  line[$];
    logic [7:0]  c;
    logic [7:0]  sum;
    logic [15:0] digits;
    logic [3:0]  nib;
    int          pick, n, ndig, directed_bytes;
    bit          lower;

    // Hold reset at the start, once
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines: matching and failing checksums, both hex cases
    send_text($sformatf("$GPRMC,1*%02X\r\n", xor_of("GPRMC,1")));
    send_text($sformatf("$GPRMC,1*%02x\n", xor_of("GPRMC,1") ^ 8'h01));
    // Empty lines give nothing
    send_text("\n");
    send_text("\r\n");
    // No star, a lone dollar, later dollars as body bytes, carriage return mid-line
    send_text("ABC\n");
    send_text("$\n");
    send_text("A$B$\n");
    send_text("$$*24\n");
    send_text("A\rB\n");
    // Star with no digits; overflow keeps the last two; mixed case
    send_text("*\n");
    send_text("XY*1234\n");
    send_text("XY*aBcD\n");
    // Non-hex bytes end the digits: letter, space, sign, 0x prefix
    send_text("Q*1G5\n");
    send_text("Q* 51\n");
    send_text("Q*-5\n");
    send_text("Q*0x51\n");
    // Zero byte as first byte, and zero ending the body before a star
    send_byte(CH_NUL);
    send_byte(CH_LF);
    send_text("AB");
    send_byte(CH_NUL);
    send_text("C*41\n");
    // Top-bit bytes in the body
    send_byte(8'hFF);
    send_byte(8'h80);
    send_text("*7F\n");
    // Longest accepted line, with and without a leading dollar
    repeat (LINE_MAX_DEF - 1) send_byte("A");
    send_byte(CH_LF);
    send_byte(CH_DOLLAR);
    repeat (LINE_MAX_DEF - 2) send_byte("z");
    send_byte(CH_LF);
    // One byte too many: drop the line, flush through CR and star to newline
    repeat (LINE_MAX_DEF) send_byte("B");
    send_text("*00\r\n");
    send_text("x\n");
    directed_bytes = bytes_sent;

    // Random lines: mostly sentences with random content, some noise
    while (bytes_sent - directed_bytes < RANDOM_BYTES) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      line.delete();
      if (pick < 8) begin
        // noise: any byte, newline included
        n = $urandom_range(1, 16);
        repeat (n) line.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 12) begin
        if ($urandom_range(0, 1) == 1) line.push_back(CH_CR);
        line.push_back(CH_LF);
      end else begin
        if ($urandom_range(0, 1) == 1) line.push_back(CH_DOLLAR);
        // mostly short bodies, now and then around the length limit
        n = ($urandom_range(0, 24) == 0) ? $urandom_range(120, 130) : $urandom_range(0, 20);
        sum = 8'h00;
        repeat (n) begin
          c = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(8'h20, 8'h7E));
          if (c == CH_LF) c = 8'h5F;
          sum ^= c;
          line.push_back(c);
        end
        if ($urandom_range(0, 4) != 0) begin
          line.push_back(CH_STAR);
          if ($urandom_range(0, 3) == 0) sum = 8'($urandom);
          ndig  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4) : 2;
          lower = 1'($urandom_range(0, 1));
          digits = {8'($urandom), sum};
          for (int i = ndig - 1; i >= 0; i--) begin
            nib = digits[4*i +: 4];
            c = (nib < 4'd10) ? 8'h30 + 8'(nib) : (lower ? 8'h57 : 8'h37) + 8'(nib);
            line.push_back(c);
          end
          if ($urandom_range(0, 5) == 0) line.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end
        if ($urandom_range(0, 1) == 1) line.push_back(CH_CR);
        line.push_back(CH_LF);
      end
      foreach (line[k]) send_byte(line[k]);
    end
    in_tvalid <= 1'b0;

    // Drain: let the checker see the last byte, wait for every predicted line,
    // then a few cycles for strays
    @(posedge clk);
    while (lines_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes (%0d directed), checked %0d lines: %0d match, %0d mismatch,",
             bytes_sent, directed_bytes, lines_checked, n_match, n_mismatch);
    $display("%0d without checksum, %0d overlong lines dropped, %0d cycles",
             n_plain, overlong_drops, cycles);
    if (fail_count == 0) begin
      $display("tb_xor_checksum_line_framer: clean");
    end else begin
      $display("tb_xor_checksum_line_framer: errors");
    end
    $finish;
  end

endmodule
